@@ rtl/bacc_pkg.sv @@
// Shared types, constants and BCD digit step functions for the alarm clock controller.
// Used by bcd_alarm_clock_controller_top; depends on nothing else.
package bacc_pkg;

  localparam int unsigned THRESHOLD_W = 6;
  localparam int unsigned DURATION_W  = 10;
  localparam int unsigned CFG_DATA_W  = 10;

  localparam logic [THRESHOLD_W-1:0] RESET_THRESHOLD = 6'd50;
  localparam logic [DURATION_W-1:0]  RESET_DURATION  = 10'd560;

  // Blink phase runs alongside the alarm counter, modulo five.
  localparam int unsigned BLINK_PERIOD = 5;
  localparam int unsigned PHASE_W      = $clog2(BLINK_PERIOD);
  localparam logic [PHASE_W-1:0] PHASE_DARK = PHASE_W'(1);
  localparam logic [PHASE_W-1:0] PHASE_LIT  = PHASE_W'(0);
  localparam logic [PHASE_W-1:0] PHASE_LAST = PHASE_W'(BLINK_PERIOD - 1);

  localparam logic [3:0] POINTS_MINUTES = 4'd3;
  localparam logic [3:0] POINTS_HOURS   = 4'd12;

  typedef enum logic {
    CFG_THRESHOLD = 1'b0,
    CFG_DURATION  = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    MODE_SET_CLOCK = 2'd0,
    MODE_SET_ALARM = 2'd1,
    MODE_DISPLAY   = 2'd2,
    MODE_ALARMING  = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] hr_tens;
    logic [3:0] hr_ones;
    logic [2:0] min_tens;
    logic [3:0] min_ones;
  } bcd_time_t;

  localparam bcd_time_t TIME_ZERO = '{hr_tens: 2'd0, hr_ones: 4'd0,
                                      min_tens: 3'd0, min_ones: 4'd0};
  localparam bcd_time_t TIME_NOON = '{hr_tens: 2'd1, hr_ones: 4'd2,
                                      min_tens: 3'd0, min_ones: 4'd0};

  function automatic bcd_time_t min_up(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.min_ones == 4'd9) begin
      r.min_ones = 4'd0;
      r.min_tens = (t.min_tens == 3'd5) ? 3'd0 : t.min_tens + 3'd1;
    end else begin
      r.min_ones = t.min_ones + 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t min_down(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.min_ones == 4'd0) begin
      r.min_ones = 4'd9;
      r.min_tens = (t.min_tens == 3'd0) ? 3'd5 : t.min_tens - 3'd1;
    end else begin
      r.min_ones = t.min_ones - 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t hr_up(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.hr_tens == 2'd2 && t.hr_ones == 4'd3) begin
      r.hr_tens = 2'd0;
      r.hr_ones = 4'd0;
    end else if (t.hr_ones == 4'd9) begin
      r.hr_tens = t.hr_tens + 2'd1;
      r.hr_ones = 4'd0;
    end else begin
      r.hr_ones = t.hr_ones + 4'd1;
    end
    return r;
  endfunction

  function automatic bcd_time_t hr_down(bcd_time_t t);
    bcd_time_t r;
    r = t;
    if (t.hr_ones == 4'd0) begin
      if (t.hr_tens == 2'd0) begin
        r.hr_ones = 4'd3;
        r.hr_tens = 2'd2;
      end else begin
        r.hr_ones = 4'd9;
        r.hr_tens = t.hr_tens - 2'd1;
      end
    end else begin
      r.hr_ones = t.hr_ones - 4'd1;
    end
    return r;
  endfunction

  // Apply the up pulse, then the down pulse, to the field being edited.
  function automatic bcd_time_t edit_step(bcd_time_t t, logic hours, logic up, logic down);
    bcd_time_t r;
    r = t;
    if (!hours) begin
      if (up)   r = min_up(r);
      if (down) r = min_down(r);
    end else begin
      if (up)   r = hr_up(r);
      if (down) r = hr_down(r);
    end
    return r;
  endfunction

endpackage

@@ rtl/bcd_alarm_clock_controller_top.sv @@
// Top level of the 24-hour BCD alarm clock controller: button edge detect, time keeping,
// mode sequencing and a registered result word. Depends on bacc_pkg.
//
// Usage
//   Input channel: one word per loop tick, carrying the five raw button levels
//   (btn_*_i), qualified by in_valid_i; the block pushes back with in_stall_o.
//   Output channel: one result word per input word (mode, shown digits, decimal
//   points, blank and tone enable), qualified by out_valid_o; the consumer pushes
//   back with out_stall_i.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i (0: minute
//   tick threshold, 1: alarm duration in ticks). Write only while no word is in
//   flight.
// Timing
//   The result for a word is written into the result register at the edge that
//   accepts it. Throughput is one word per cycle while out_stall_i is low, set by the
//   single result register; all state updates happen in that same edge.
//   While the consumer stalls, the result register holds and in_stall_o rises,
//   so at most one finished word waits. A new word is taken in the cycle the
//   waiting one is drained.
// Reset
//   rst_ni clears all state: mode set clock, time and alarm 00:00, locks clear,
//   threshold 50 and duration 560, no result pending.
module bcd_alarm_clock_controller_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [bacc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input words
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       btn_center_i,
  input  logic       btn_up_i,
  input  logic       btn_left_i,
  input  logic       btn_down_i,
  input  logic       btn_right_i,
  // result words
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] mode_o,
  output logic [3:0] show_min_ones_o,
  output logic [2:0] show_min_tens_o,
  output logic [3:0] show_hr_ones_o,
  output logic [1:0] show_hr_tens_o,
  output logic [3:0] point_mask_o,
  output logic       blank_o,
  output logic       tone_on_o
);

  localparam int unsigned NUM_LOCKS = 6;
  localparam int unsigned LOCK_C  = 0;
  localparam int unsigned LOCK_U  = 1;
  localparam int unsigned LOCK_L  = 2;
  localparam int unsigned LOCK_D  = 3;
  localparam int unsigned LOCK_R  = 4;
  localparam int unsigned LOCK_CR = 5;

  // Configuration registers
  logic [bacc_pkg::THRESHOLD_W-1:0] thr_q;
  logic [bacc_pkg::DURATION_W-1:0]  dur_q;

  // Controller state
  bacc_pkg::mode_e                  mode_q, mode_d;
  bacc_pkg::bcd_time_t              time_q, time_d;
  bacc_pkg::bcd_time_t              alarm_q, alarm_d;
  logic                             edit_hours_q, edit_hours_d;
  logic [bacc_pkg::THRESHOLD_W-1:0] tick_q, tick_d;
  logic [bacc_pkg::DURATION_W-1:0]  count_q, count_d;
  logic [bacc_pkg::PHASE_W-1:0]     phase_q, phase_d;
  logic [NUM_LOCKS-1:0]             locks_q, locks_d;
  logic [3:0]                       points_q, points_d;
  logic                             blank_q, blank_d;
  logic                             tone_q, tone_d;
  logic                             match_q, match_d;

  // Result register
  logic                             out_valid_q;
  logic [1:0]                       out_mode_q;
  bacc_pkg::bcd_time_t              out_show_q, out_show_d;
  logic [3:0]                       out_points_q, out_points_d;
  logic                             out_blank_q, out_blank_d;
  logic                             out_tone_q;

  logic in_fire;
  logic pc, pu, pl, pd, pr, pcr;
  logic roll;

  // Take a word whenever the result slot is free or drains this cycle.
  assign in_stall_o = out_valid_q & out_stall_i;
  assign in_fire    = in_valid_i & ~in_stall_o;

  // Press pulses: a lock follows the level, so a pulse is level high with lock clear.
  assign pc = btn_center_i & ~locks_q[LOCK_C];
  assign pu = btn_up_i     & ~locks_q[LOCK_U];
  assign pl = btn_left_i   & ~locks_q[LOCK_L];
  assign pd = btn_down_i   & ~locks_q[LOCK_D];
  assign pr = btn_right_i  & ~locks_q[LOCK_R];
  // Combined lock releases only once both buttons are up.
  assign pcr = btn_center_i & btn_right_i & ~locks_q[LOCK_CR];

  assign roll = (tick_q > thr_q);

  always_comb begin
    mode_d       = mode_q;
    time_d       = time_q;
    alarm_d      = alarm_q;
    tick_d       = tick_q;
    count_d      = count_q;
    phase_d      = phase_q;
    points_d     = points_q;
    blank_d      = blank_q;
    tone_d       = tone_q;

    locks_d[LOCK_C]  = btn_center_i;
    locks_d[LOCK_U]  = btn_up_i;
    locks_d[LOCK_L]  = btn_left_i;
    locks_d[LOCK_D]  = btn_down_i;
    locks_d[LOCK_R]  = btn_right_i;
    locks_d[LOCK_CR] = (btn_center_i & btn_right_i) |
                       (locks_q[LOCK_CR] & (btn_center_i | btn_right_i));

    edit_hours_d = edit_hours_q ^ pl;

    // Advance the clock outside set clock mode.
    if (mode_q != bacc_pkg::MODE_SET_CLOCK) begin
      if (roll) begin
        tick_d = '0;
        if (time_q.min_ones == 4'd9 && time_q.min_tens == 3'd5) begin
          time_d = bacc_pkg::hr_up(time_q);
        end
        time_d = bacc_pkg::min_up(time_d);
      end else begin
        tick_d = tick_q + bacc_pkg::THRESHOLD_W'(1);
      end
    end

    unique case (mode_q)
      bacc_pkg::MODE_SET_CLOCK: begin
        if (pr) begin
          time_d = bacc_pkg::TIME_ZERO;
        end else if (pc) begin
          mode_d  = bacc_pkg::MODE_SET_ALARM;
          alarm_d = bacc_pkg::TIME_NOON;
        end
        points_d = edit_hours_d ? bacc_pkg::POINTS_HOURS : bacc_pkg::POINTS_MINUTES;
        time_d   = bacc_pkg::edit_step(time_d, edit_hours_d, pu, pd);
      end
      bacc_pkg::MODE_SET_ALARM: begin
        if (pr) begin
          mode_d = bacc_pkg::MODE_SET_CLOCK;
          time_d = bacc_pkg::TIME_ZERO;
        end else if (pc) begin
          mode_d = bacc_pkg::MODE_DISPLAY;
        end
        points_d = edit_hours_d ? bacc_pkg::POINTS_HOURS : bacc_pkg::POINTS_MINUTES;
        alarm_d  = bacc_pkg::edit_step(alarm_q, edit_hours_d, pu, pd);
      end
      bacc_pkg::MODE_DISPLAY: begin
        if (pr) begin
          mode_d = bacc_pkg::MODE_SET_CLOCK;
          time_d = bacc_pkg::TIME_ZERO;
        end else if (pc) begin
          mode_d = bacc_pkg::MODE_SET_ALARM;
        end
        // Fire only on the first tick of a match.
        if (time_d == alarm_q && !match_q) begin
          mode_d  = bacc_pkg::MODE_ALARMING;
          count_d = '0;
          phase_d = bacc_pkg::PHASE_LIT;
          blank_d = 1'b0;
        end
      end
      bacc_pkg::MODE_ALARMING: begin
        if (count_q == dur_q) begin
          tone_d = 1'b0;
          mode_d = bacc_pkg::MODE_DISPLAY;
        end else begin
          if (phase_q == bacc_pkg::PHASE_DARK) begin
            blank_d = 1'b1;
          end else if (phase_q == bacc_pkg::PHASE_LIT) begin
            blank_d = 1'b0;
          end
          tone_d  = 1'b1;
          count_d = count_q + bacc_pkg::DURATION_W'(1);
          // Keep the phase equal to the count modulo five, across the count wrap too.
          if (count_q == '1 || phase_q == bacc_pkg::PHASE_LAST) begin
            phase_d = bacc_pkg::PHASE_LIT;
          end else begin
            phase_d = phase_q + bacc_pkg::PHASE_W'(1);
          end
        end
        if (pcr) begin
          tone_d = 1'b0;
          mode_d = bacc_pkg::MODE_DISPLAY;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase

    match_d = (time_d == alarm_d);
  end

  // Build the result word from the updated state.
  always_comb begin
    out_blank_d  = (mode_d == bacc_pkg::MODE_ALARMING) & blank_d;
    out_points_d = points_d;
    if (mode_d == bacc_pkg::MODE_SET_ALARM || mode_d == bacc_pkg::MODE_ALARMING) begin
      out_show_d = alarm_d;
    end else begin
      out_show_d = time_d;
    end
    if (out_blank_d) begin
      out_show_d   = bacc_pkg::TIME_ZERO;
      out_points_d = '0;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= bacc_pkg::RESET_THRESHOLD;
      dur_q <= bacc_pkg::RESET_DURATION;
    end else if (cfg_we_i) begin
      case (bacc_pkg::cfg_idx_e'(cfg_idx_i))
        bacc_pkg::CFG_THRESHOLD: thr_q <= cfg_data_i[bacc_pkg::THRESHOLD_W-1:0];
        bacc_pkg::CFG_DURATION:  dur_q <= cfg_data_i[bacc_pkg::DURATION_W-1:0];
        default:                 thr_q <= thr_q;
      endcase
    end
  end

  // Controller state: advance once per accepted word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= bacc_pkg::MODE_SET_CLOCK;
      time_q       <= bacc_pkg::TIME_ZERO;
      alarm_q      <= bacc_pkg::TIME_ZERO;
      edit_hours_q <= 1'b0;
      tick_q       <= '0;
      count_q      <= '0;
      phase_q      <= bacc_pkg::PHASE_LIT;
      locks_q      <= '0;
      points_q     <= '0;
      blank_q      <= 1'b0;
      tone_q       <= 1'b0;
      match_q      <= 1'b0;
    end else if (in_fire) begin
      mode_q       <= mode_d;
      time_q       <= time_d;
      alarm_q      <= alarm_d;
      edit_hours_q <= edit_hours_d;
      tick_q       <= tick_d;
      count_q      <= count_d;
      phase_q      <= phase_d;
      locks_q      <= locks_d;
      points_q     <= points_d;
      blank_q      <= blank_d;
      tone_q       <= tone_d;
      match_q      <= match_d;
    end
  end

  // Result slot valid: set on accept, drop when drained without a new word.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payload: hold while stalled.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_mode_q   <= mode_d;
      out_show_q   <= out_show_d;
      out_points_q <= out_points_d;
      out_blank_q  <= out_blank_d;
      out_tone_q   <= tone_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mode_o          = out_mode_q;
  assign show_min_ones_o = out_show_q.min_ones;
  assign show_min_tens_o = out_show_q.min_tens;
  assign show_hr_ones_o  = out_show_q.hr_ones;
  assign show_hr_tens_o  = out_show_q.hr_tens;
  assign point_mask_o    = out_points_q;
  assign blank_o         = out_blank_q;
  assign tone_on_o       = out_tone_q;

`ifndef SYNTHESIS
  // Every accepted word leaves a result in the slot at the next edge.
  a_accept_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_q)
    else $error("accepted word left no result");

  // The tone only sounds while alarming.
  a_tone_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tone_q |-> mode_q == bacc_pkg::MODE_ALARMING)
    else $error("tone on outside alarming mode");

  // Alarming is entered only from display.
  a_alarm_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == bacc_pkg::MODE_ALARMING && $past(mode_q) != bacc_pkg::MODE_ALARMING)
      |-> $past(mode_q) == bacc_pkg::MODE_DISPLAY)
    else $error("alarming entered from a mode other than display");

  // Kept time stays a legal BCD time of day.
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    time_q.min_ones <= 4'd9 && time_q.min_tens <= 3'd5 && time_q.hr_ones <= 4'd9 &&
    (time_q.hr_tens < 2'd2 || (time_q.hr_tens == 2'd2 && time_q.hr_ones <= 4'd3)))
    else $error("time digits out of range");
`endif

endmodule

@@ test/tb_clock_face_pkg.sv @@
`timescale 1ns / 100ps
// Button masks, result type and the tracker that predicts and checks the alarm clock's results.
// Depends on bacc_pkg for the mode, register index and BCD time types.
package tb_clock_face_pkg;
  import bacc_pkg::*;

  // Bit order of a button word: {center, up, left, down, right}.
  localparam logic [4:0] B_C = 5'b10000;
  localparam logic [4:0] B_U = 5'b01000;
  localparam logic [4:0] B_L = 5'b00100;
  localparam logic [4:0] B_D = 5'b00010;
  localparam logic [4:0] B_R = 5'b00001;

  typedef struct packed {
    mode_e      mode;
    logic [3:0] min_ones;
    logic [2:0] min_tens;
    logic [3:0] hr_ones;
    logic [1:0] hr_tens;
    logic [3:0] points;
    logic       blank;
    logic       tone;
  } face_t;

  class face_tracker;
    logic [5:0]  threshold;
    logic [9:0]  duration;
    mode_e       mode;
    bcd_time_t   clock;
    bcd_time_t   alarm;
    logic        edit_hours;
    logic [5:0]  tick_count;
    logic [9:0]  alarm_count;
    logic [5:0]  locks;
    logic [3:0]  points;
    logic        blank_q;
    logic        tone_q;
    logic        match_q;
    face_t       pending_faces[$];
    int unsigned mismatches;
    int unsigned accepted;

    function new();
      threshold   = RESET_THRESHOLD;
      duration    = RESET_DURATION;
      mode        = MODE_SET_CLOCK;
      clock       = TIME_ZERO;
      alarm       = TIME_ZERO;
      edit_hours  = 1'b0;
      tick_count  = '0;
      alarm_count = '0;
      locks       = '0;
      points      = '0;
      blank_q     = 1'b0;
      tone_q      = 1'b0;
      match_q     = 1'b0;
      mismatches  = 0;
      accepted    = 0;
    endfunction

    function int minute_of(bcd_time_t t);
      return int'(t.min_tens) * 10 + int'(t.min_ones);
    endfunction

    function int hour_of(bcd_time_t t);
      return int'(t.hr_tens) * 10 + int'(t.hr_ones);
    endfunction

    function bcd_time_t with_minute(bcd_time_t t, int v);
      t.min_tens = 3'(v / 10);
      t.min_ones = 4'(v % 10);
      return t;
    endfunction

    function bcd_time_t with_hour(bcd_time_t t, int v);
      t.hr_tens = 2'(v / 10);
      t.hr_ones = 4'(v % 10);
      return t;
    endfunction

    // Up first, then down, on whichever half is being edited.
    function bcd_time_t edit(bcd_time_t t, logic up, logic down);
      int v;
      if (!edit_hours) begin
        points = POINTS_MINUTES;
        v = minute_of(t);
        if (up) v = (v + 1) % 60;
        if (down) v = (v + 59) % 60;
        return with_minute(t, v);
      end
      points = POINTS_HOURS;
      v = hour_of(t);
      if (up) v = (v + 1) % 24;
      if (down) v = (v + 23) % 24;
      return with_hour(t, v);
    endfunction

    function void write_reg(cfg_idx_e idx, logic [9:0] data);
      if (idx == CFG_THRESHOLD) threshold = data[5:0];
      else duration = data;
    endfunction

    function face_t run_tick(logic [4:0] b);
      logic c, u, l, d, r;
      logic pc, pu, pl, pd, pr, pcr, roll, dark;
      int m;
      bcd_time_t shown;
      face_t f;
      c = b[4];
      u = b[3];
      l = b[2];
      d = b[1];
      r = b[0];
      pc = c & ~locks[0];
      pu = u & ~locks[1];
      pl = l & ~locks[2];
      pd = d & ~locks[3];
      pr = r & ~locks[4];
      locks[4:0] = {r, d, l, u, c};
      // The combined lock only drops once both buttons are up.
      pcr = 1'b0;
      if (c && r && !locks[5]) begin
        locks[5] = 1'b1;
        pcr = 1'b1;
      end else if (!c && !r) begin
        locks[5] = 1'b0;
      end
      if (pl) edit_hours = ~edit_hours;

      if (mode != MODE_SET_CLOCK) begin
        roll = tick_count > threshold;
        tick_count = tick_count + 6'd1;
        if (roll) begin
          tick_count = '0;
          m = minute_of(clock);
          if (m == 59) begin
            clock = with_minute(clock, 0);
            clock = with_hour(clock, (hour_of(clock) + 1) % 24);
          end else begin
            clock = with_minute(clock, m + 1);
          end
        end
      end

      case (mode)
        MODE_SET_CLOCK: begin
          if (pr) begin
            clock = TIME_ZERO;
          end else if (pc) begin
            mode = MODE_SET_ALARM;
            alarm = TIME_NOON;
          end
          clock = edit(clock, pu, pd);
        end
        MODE_SET_ALARM: begin
          if (pr) begin
            mode = MODE_SET_CLOCK;
            clock = TIME_ZERO;
          end else if (pc) begin
            mode = MODE_DISPLAY;
          end
          alarm = edit(alarm, pu, pd);
        end
        MODE_DISPLAY: begin
          if (pr) begin
            mode = MODE_SET_CLOCK;
            clock = TIME_ZERO;
          end else if (pc) begin
            mode = MODE_SET_ALARM;
          end
          if (clock == alarm && !match_q) begin
            mode = MODE_ALARMING;
            alarm_count = '0;
            blank_q = 1'b0;
          end
        end
        default: begin
          if (alarm_count == duration) begin
            tone_q = 1'b0;
            mode = MODE_DISPLAY;
          end else begin
            if (alarm_count % BLINK_PERIOD == 1) blank_q = 1'b1;
            else if (alarm_count % BLINK_PERIOD == 0) blank_q = 1'b0;
            tone_q = 1'b1;
            alarm_count = alarm_count + 10'd1;
          end
          if (pcr) begin
            tone_q = 1'b0;
            mode = MODE_DISPLAY;
          end
        end
      endcase
      match_q = (clock == alarm);

      dark = (mode == MODE_ALARMING) && blank_q;
      shown = (mode == MODE_SET_ALARM || mode == MODE_ALARMING) ? alarm : clock;
      f.mode     = mode;
      f.min_ones = dark ? 4'd0 : shown.min_ones;
      f.min_tens = dark ? 3'd0 : shown.min_tens;
      f.hr_ones  = dark ? 4'd0 : shown.hr_ones;
      f.hr_tens  = dark ? 2'd0 : shown.hr_tens;
      f.points   = dark ? 4'd0 : points;
      f.blank    = dark;
      f.tone     = tone_q;
      return f;
    endfunction

    function void note_tick(logic [4:0] b);
      accepted++;
      pending_faces.push_back(run_tick(b));
    endfunction

    function int unsigned pending();
      return pending_faces.size();
    endfunction

    function void check_face(face_t got);
      face_t want;
      int unsigned want_v[8];
      int unsigned got_v[8];
      string names[8];
      if (pending_faces.size() == 0) begin
        mismatches++;
        $display("%0t: result word arrived with nothing expected", $time);
        return;
      end
      want = pending_faces.pop_front();
      names = '{"mode", "show_min_ones", "show_min_tens", "show_hr_ones", "show_hr_tens",
                "point_mask", "blank", "tone_on"};
      want_v = '{want.mode, want.min_ones, want.min_tens, want.hr_ones, want.hr_tens,
                 want.points, want.blank, want.tone};
      got_v = '{got.mode, got.min_ones, got.min_tens, got.hr_ones, got.hr_tens,
                got.points, got.blank, got.tone};
      foreach (names[i]) begin
        if (want_v[i] != got_v[i]) begin
          mismatches++;
          $display("%0t: %s expected %0d got %0d", $time, names[i], want_v[i], got_v[i]);
        end
      end
    endfunction
  endclass

endpackage

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Testbench for the BCD alarm clock controller: drives button words and register writes,
// predicts every result word with face_tracker. Depends on bacc_pkg and tb_clock_face_pkg.
module tb_top;
  import bacc_pkg::*;
  import tb_clock_face_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned TARGET_WORDS = 1450;
  localparam int unsigned FIXED_PHASES = 6;

  // Register settings walked first: fixed extremes and middle values, then random ones.
  localparam logic [5:0] FIXED_THR[FIXED_PHASES] = '{6'd1, 6'd62, 6'd0, 6'd63, 6'd5, 6'd30};
  localparam logic [9:0] FIXED_DUR[FIXED_PHASES] = '{10'd1, 10'd1023, 10'd0, 10'd7, 10'd40,
                                                     10'd2};

  // Opening words: every button at once, then a minute wrap downward, hour wraps both ways,
  // the mode moves from set clock and back, and a combined press outside alarming.
  localparam logic [4:0] OPENING[25] = '{
    B_C | B_U | B_L | B_D | B_R, 5'd0, B_L, 5'd0, B_U, 5'd0, B_D, 5'd0, B_D, 5'd0,
    B_L, B_U, 5'd0, B_D, 5'd0, B_D, 5'd0, B_U, 5'd0, B_L,
    B_C, 5'd0, B_R, B_C | B_R, 5'd0
  };

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       cfg_we    = 1'b0;
  cfg_idx_e   cfg_idx   = CFG_THRESHOLD;
  logic [9:0] cfg_data  = '0;
  logic       in_valid  = 1'b0;
  logic [4:0] btn       = '0;
  logic       out_stall = 1'b0;
  logic       calm      = 1'b0;

  logic       in_stall;
  logic       out_valid;
  logic [1:0] shown_mode;
  logic [3:0] shown_min_ones;
  logic [2:0] shown_min_tens;
  logic [3:0] shown_hr_ones;
  logic [1:0] shown_hr_tens;
  logic [3:0] shown_points;
  logic       shown_blank;
  logic       shown_tone;

  int unsigned cycles    = 0;
  int unsigned stall_run = 0;
  face_t       seen_face;
  face_tracker faces = new();

  bcd_alarm_clock_controller_top uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .cfg_we_i        (cfg_we),
    .cfg_idx_i       (cfg_idx),
    .cfg_data_i      (cfg_data),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .btn_center_i    (btn[4]),
    .btn_up_i        (btn[3]),
    .btn_left_i      (btn[2]),
    .btn_down_i      (btn[1]),
    .btn_right_i     (btn[0]),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .mode_o          (shown_mode),
    .show_min_ones_o (shown_min_ones),
    .show_min_tens_o (shown_min_tens),
    .show_hr_ones_o  (shown_hr_ones),
    .show_hr_tens_o  (shown_hr_tens),
    .point_mask_o    (shown_points),
    .blank_o         (shown_blank),
    .tone_on_o       (shown_tone)
  );

  always #10 clk = ~clk;

  // Watchdog: fail the run once the cycle count reaches LIMIT_CYCLES, which catches a block that stops moving words.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("bcd_alarm_clock_controller_top test failed");
      $finish;
    end
  end

  // Result side: check the word taken at this edge, then pick the stall for the next one.
  // Stalls come in short bursts mostly, now and then a long one, none in calm rounds.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_face.mode     = mode_e'(shown_mode);
      seen_face.min_ones = shown_min_ones;
      seen_face.min_tens = shown_min_tens;
      seen_face.hr_ones  = shown_hr_ones;
      seen_face.hr_tens  = shown_hr_tens;
      seen_face.points   = shown_points;
      seen_face.blank    = shown_blank;
      seen_face.tone     = shown_tone;
      faces.check_face(seen_face);
    end
    if (calm) begin
      out_stall <= 1'b0;
    end else if (stall_run != 0) begin
      out_stall <= 1'b1;
      stall_run--;
    end else begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4: begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(0, 2);
        end
        5: begin
          out_stall <= 1'b1;
          stall_run = $urandom_range(5, 25);
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(5, 20);
  endfunction

  function automatic logic [4:0] updown();
    return $urandom_range(0, 1) ? B_U : B_D;
  endfunction

  // Mostly nothing pressed; now and then a button that display mode ignores or a left.
  function automatic logic [4:0] quiet_word();
    case ($urandom_range(0, 19))
      0: return B_L;
      1: return B_U;
      2: return B_D;
      default: return 5'd0;
    endcase
  endfunction

  // Single presses only, so the alarm is not dismissed by accident.
  function automatic logic [4:0] alarm_word();
    case ($urandom_range(0, 19))
      0: return B_C;
      1: return B_R;
      2: return B_U;
      3: return B_D;
      4: return B_L;
      default: return 5'd0;
    endcase
  endfunction

  // Hold off a random gap, present the word, hold it until taken, then note it.
  // Valid stays high afterwards so back-to-back words leave no idle gap between them.
  task automatic send_word(logic [4:0] w);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    btn <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    faces.note_tick(w);
  endtask

  // Press for one tick or sometimes two, then release so the lock clears.
  task automatic tap(logic [4:0] w);
    repeat ($urandom_range(0, 3) == 0 ? 2 : 1) send_word(w);
    send_word(5'd0);
  endtask

  // Stop sending and wait for every predicted word to come out.
  task automatic settle();
    in_valid <= 1'b0;
    while (faces.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_settings(logic [5:0] thr, logic [9:0] dur);
    logic [9:0] reg_value;
    settle();
    // Upper data bits are don't-care for the threshold; drive them at random.
    reg_value = {4'($urandom_range(0, 15)), thr};
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_THRESHOLD;
    cfg_data <= reg_value;
    faces.write_reg(CFG_THRESHOLD, reg_value);
    @(posedge clk);
    cfg_idx  <= CFG_DURATION;
    cfg_data <= dur;
    faces.write_reg(CFG_DURATION, dur);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Leave whatever mode the block is in; a right press can itself start an alarm.
  task automatic go_set_clock();
    repeat (4) begin
      if (faces.mode == MODE_ALARMING) tap(B_C | B_R);
      else if (faces.mode != MODE_SET_CLOCK) tap(B_R);
    end
  endtask

  // In set clock the time stands still, so walk hours then minutes the short way round.
  task automatic steer_clock(int hr, int mn);
    int d;
    if (!faces.edit_hours) tap(B_L);
    d = (hr - faces.hour_of(faces.clock) + 24) % 24;
    if (d <= 12) repeat (d) tap(B_U);
    else repeat (24 - d) tap(B_D);
    tap(B_L);
    d = (mn - faces.minute_of(faces.clock) + 60) % 60;
    if (d <= 30) repeat (d) tap(B_U);
    else repeat (60 - d) tap(B_D);
  endtask

  // Full use case: set the time, mostly at or a few minutes short of noon (the alarm preset), arm,
  // wait in display for the match, then let the alarm run out or dismiss it.
  task automatic alarm_round();
    int unsigned pick, k, bound, n;
    int hr, mn;
    go_set_clock();
    pick = $urandom_range(0, 9);
    k = $urandom_range(0, 3);
    if (pick < 6) begin
      hr = (k == 0) ? 12 : 11;
      mn = (60 - k) % 60;
    end else if (pick < 8) begin
      // Run through midnight instead.
      hr = 23;
      mn = 59 - k;
    end else begin
      hr = $urandom_range(0, 23);
      mn = $urandom_range(0, 59);
    end
    steer_clock(hr, mn);
    if ($urandom_range(0, 3) == 0) tap(updown());
    tap(B_C);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) tap(updown());
    tap(B_C);

    bound = (faces.threshold == 6'd63) ? 20 : (int'(faces.threshold) + 2) * 5 + 10;
    n = 0;
    while (faces.mode == MODE_DISPLAY && n < bound) begin
      send_word(quiet_word());
      n++;
    end

    if (faces.mode == MODE_ALARMING) begin
      if (faces.duration <= 60 && $urandom_range(0, 2) != 0) begin
        n = 0;
        while (faces.mode == MODE_ALARMING && n < int'(faces.duration) + 5) begin
          send_word(alarm_word());
          n++;
        end
      end else begin
        n = $urandom_range(0, 30);
        while (faces.mode == MODE_ALARMING && n != 0) begin
          send_word(alarm_word());
          n--;
        end
        // Dismiss with both buttons together, or center first and right added later.
        if ($urandom_range(0, 1)) begin
          tap(B_C | B_R);
        end else begin
          send_word(B_C);
          send_word(B_C | B_R);
          send_word(5'd0);
        end
      end
    end
  endtask

  // Broken sequences: single presses held or released at random, some chords.
  task automatic fuzz_round();
    int unsigned r;
    repeat ($urandom_range(10, 30)) begin
      r = $urandom_range(0, 9);
      if (r < 4) send_word(5'd0);
      else if (r < 8) send_word(5'd1 << $urandom_range(0, 4));
      else send_word(5'($urandom_range(0, 31)));
    end
  endtask

  task automatic noise_round();
    repeat ($urandom_range(10, 30)) send_word(5'($urandom_range(0, 31)));
  endtask

  initial begin
    int unsigned phase;
    logic [5:0] thr;
    logic [9:0] dur;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (OPENING[i]) send_word(OPENING[i]);
    // One full alarm round on the reset settings before any register write.
    alarm_round();

    phase = 0;
    while (phase < FIXED_PHASES || faces.accepted < TARGET_WORDS) begin
      if (phase < FIXED_PHASES) begin
        thr = FIXED_THR[phase];
        dur = FIXED_DUR[phase];
      end else if ($urandom_range(0, 3) == 0) begin
        thr = 6'($urandom_range(0, 63));
        dur = 10'($urandom_range(0, 1023));
      end else begin
        // Short minutes and short alarms keep the rounds quick.
        thr = 6'($urandom_range(0, 12));
        dur = 10'($urandom_range(0, 40));
      end
      write_settings(thr, dur);
      repeat ($urandom_range(2, 4)) begin
        calm = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 4) == 0) settle();
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4, 5: alarm_round();
          6, 7: fuzz_round();
          default: noise_round();
        endcase
      end
      phase++;
    end

    calm = 1'b0;
    settle();
    repeat (5) @(posedge clk);
    if (faces.mismatches == 0 && faces.pending() == 0)
      $display("bcd_alarm_clock_controller_top test passed");
    else
      $display("bcd_alarm_clock_controller_top test failed");
    $finish;
  end

endmodule
